### rtl/core/u2d_pkg.sv
// Shared types and constants for the 16-bit to decimal ASCII converter.
// No dependencies; used by u2d_cell and u16_to_decimal_ascii.
`default_nettype none

package u2d_pkg;

    localparam int VAL_W    = 16;
    localparam int DIG_W    = 4;
    localparam int CHAR_W   = 6;
    localparam int N_PLACES = 5;

    localparam logic [VAL_W-1:0] PLACE_VALUES [N_PLACES] = '{
        16'd10000, 16'd1000, 16'd100, 16'd10, 16'd1
    };

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;
    localparam logic [CHAR_W-1:0] ASCII_NINE = 6'd57;

    typedef struct packed {
        logic             act;
        logic             started;
        logic [VAL_W-1:0] rem;
    } t_tok;

    typedef struct packed {
        logic             valid;
        logic [DIG_W-1:0] dig;
        logic             last;
    } t_emit;

endpackage

`default_nettype wire

### rtl/core/u2d_cell.sv
// One decimal place of the converter: subtracts its place value once per cycle,
// then offers its digit and hands the remainder to the next place. Uses u2d_pkg.
`default_nettype none

module u2d_cell (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire u2d_pkg::t_tok            i_tok,
    input  wire logic [u2d_pkg::VAL_W-1:0] i_place,
    input  wire logic                     i_ones,
    input  wire logic                     i_emit_ok,
    output u2d_pkg::t_tok                 o_tok,
    output u2d_pkg::t_emit                o_emit,
    output logic                          o_busy
);

    logic                        r_act;
    logic                        r_started;
    logic [u2d_pkg::VAL_W-1:0]   r_rem;
    logic [u2d_pkg::DIG_W-1:0]   r_dig;
    logic                        n_act;
    logic                        n_started;
    logic [u2d_pkg::VAL_W-1:0]   n_rem;
    logic [u2d_pkg::DIG_W-1:0]   n_dig;

    logic w_done;
    logic w_need;
    logic w_leave;

    assign w_done  = r_act && (r_rem < i_place);
    assign w_need  = r_started || (r_dig != '0) || i_ones;
    assign w_leave = w_done && (!w_need || i_emit_ok);

    always_comb begin
        n_act     = r_act;
        n_started = r_started;
        n_rem     = r_rem;
        n_dig     = r_dig;
        if (i_tok.act) begin
            n_act     = 1'b1;
            n_started = i_tok.started;
            n_rem     = i_tok.rem;
            n_dig     = '0;
        end else if (r_act && !w_done) begin
            n_rem = r_rem - i_place;
            n_dig = r_dig + 1'b1;
        end else if (w_leave) begin
            n_act = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
        end else begin
            r_act <= n_act;
        end
        r_started <= n_started;
        r_rem     <= n_rem;
        r_dig     <= n_dig;
    end

    always_comb begin
        o_tok.act     = w_leave;
        o_tok.started = r_started || w_need;
        o_tok.rem     = r_rem;
        o_emit.valid  = w_done && w_need;
        o_emit.dig    = r_dig;
        o_emit.last   = i_ones;
    end

    assign o_busy = r_act;

endmodule

`default_nettype wire

### rtl/core/u16_to_decimal_ascii.sv
// Top level: unsigned 16-bit value to decimal ASCII digits, leading zeros dropped.
// Chains five u2d_cell places and an output register. Uses u2d_pkg.
//
//   channel | direction | handshake          | word
//   input   | in        | i_valid / o_stall  | i_value[15:0]
//   output  | out       | o_valid / i_stall  | o_digit_char[5:0], o_last
//
// Each place cell finds its digit by subtracting its place value in a loop; a digit
// that is to be shown waits in its cell while the output register is stalled. A new
// value is taken once all place cells are idle, even while the last character still
// waits in the output register. Reset is synchronous, active low, and clears all
// control state.
`default_nettype none

module u16_to_decimal_ascii (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_stall,
    input  wire logic [u2d_pkg::VAL_W-1:0]  i_value,
    output logic                            o_valid,
    input  wire logic                       i_stall,
    output logic [u2d_pkg::CHAR_W-1:0]      o_digit_char,
    output logic                            o_last
);

    u2d_pkg::t_tok               w_tok_in  [u2d_pkg::N_PLACES];
    u2d_pkg::t_tok               w_tok_out [u2d_pkg::N_PLACES];
    u2d_pkg::t_emit              w_emit    [u2d_pkg::N_PLACES];
    logic [u2d_pkg::N_PLACES-1:0] w_busy;

    logic                        w_accept;
    logic                        w_emit_ok;
    logic                        w_any_emit;
    logic [u2d_pkg::DIG_W-1:0]   w_dig;
    logic                        w_last;

    logic                        r_out_valid;
    logic [u2d_pkg::CHAR_W-1:0]  r_out_char;
    logic                        r_out_last;

    assign o_stall   = |w_busy;
    assign w_accept  = i_valid && !o_stall;
    assign w_emit_ok = !r_out_valid || !i_stall;

    always_comb begin
        w_tok_in[0].act     = w_accept;
        w_tok_in[0].started = 1'b0;
        w_tok_in[0].rem     = i_value;
        for (int k = 1; k < u2d_pkg::N_PLACES; k++) begin
            w_tok_in[k] = w_tok_out[k-1];
        end
    end

    for (genvar g = 0; g < u2d_pkg::N_PLACES; g++) begin : g_place
        u2d_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_tok     (w_tok_in[g]),
            .i_place   (u2d_pkg::PLACE_VALUES[g]),
            .i_ones    (g == u2d_pkg::N_PLACES - 1),
            .i_emit_ok (w_emit_ok),
            .o_tok     (w_tok_out[g]),
            .o_emit    (w_emit[g]),
            .o_busy    (w_busy[g])
        );
    end

    always_comb begin
        w_any_emit = 1'b0;
        w_dig      = '0;
        w_last     = 1'b0;
        for (int k = 0; k < u2d_pkg::N_PLACES; k++) begin
            w_any_emit = w_any_emit | w_emit[k].valid;
            w_dig      = w_dig | ({u2d_pkg::DIG_W{w_emit[k].valid}} & w_emit[k].dig);
            w_last     = w_last | (w_emit[k].valid & w_emit[k].last);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit_ok) begin
            r_out_valid <= w_any_emit;
        end
        if (w_emit_ok && w_any_emit) begin
            r_out_char <= u2d_pkg::ASCII_ZERO + {{(u2d_pkg::CHAR_W-u2d_pkg::DIG_W){1'b0}}, w_dig};
            r_out_last <= w_last;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_digit_char = r_out_char;
    assign o_last       = r_out_last;

    a_one_place: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_busy))
        else $error("more than one place active");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_stall)
        else $error("value taken but no place active");

    a_ones_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tok_out[u2d_pkg::N_PLACES-1].act |-> w_emit[u2d_pkg::N_PLACES-1].valid)
        else $error("ones place left without a digit");

    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_digit_char >= u2d_pkg::ASCII_ZERO && o_digit_char <= u2d_pkg::ASCII_NINE))
        else $error("character outside digit range");

endmodule

`default_nettype wire

### tb/tb_u16_to_decimal_ascii.sv
// Self-checking testbench for u16_to_decimal_ascii: directed table, then random words.
// Predicts the digit characters per value; depends on u2d_pkg and the RTL only.
`timescale 1ns / 1ps

module tb_u16_to_decimal_ascii;

    localparam int N_DIR           = 21;
    localparam int N_RANDOM        = 189;
    localparam int QUIET_TAIL      = 30;
    localparam int PRESSURE_AT     = 40;
    localparam int PRESSURE_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 60;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int MAX_REPORTS     = 10;

    localparam int unsigned DECADES [u2d_pkg::N_PLACES] = '{10000, 1000, 100, 10, 1};

    typedef struct packed {
        logic [u2d_pkg::CHAR_W-1:0] digit_char;
        logic                       last;
    } t_ascii_digit;

    localparam logic [u2d_pkg::VAL_W-1:0] DIRECTED_VALUES [N_DIR] = '{
        16'd0,     16'd65535, 16'd1,     16'd9,     16'd10,    16'd99,    16'd100,
        16'd999,   16'd1000,  16'd9999,  16'd10000, 16'd10001, 16'd10203, 16'd60006,
        16'd40500, 16'd32768, 16'd12345, 16'd21845, 16'd43690, 16'd59999, 16'd7
    };

    string directed_text [N_DIR] = '{
        "0",  "65535", "1",  "9",  "10", "",   "100",
        "",   "",      "9999", "10000", "", "", "",
        "",   "",      "",   "",   "",   "",   ""
    };

    logic                       i_clk   = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_valid = 1'b0;
    logic [u2d_pkg::VAL_W-1:0]  i_value = '0;
    logic                       i_stall = 1'b0;
    logic                       o_stall;
    logic                       o_valid;
    logic [u2d_pkg::CHAR_W-1:0] o_digit_char;
    logic                       o_last;

    t_ascii_digit digits_due [$];
    int unsigned  fail_count    = 0;
    int unsigned  values_sent   = 0;
    int unsigned  quiet_cycles  = 0;
    bit           bursts_on     = 1'b0;
    bit           pressure_done = 1'b0;

    u16_to_decimal_ascii i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_digit_char (o_digit_char),
        .o_last       (o_last)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic void push_decimal_digits(input logic [u2d_pkg::VAL_W-1:0] value);
        int unsigned  rest;
        int unsigned  dig;
        bit           leading;
        t_ascii_digit d;
        rest    = value;
        leading = 1'b1;
        for (int p = 0; p < u2d_pkg::N_PLACES; p++) begin
            dig = 0;
            while (rest >= DECADES[p]) begin
                rest -= DECADES[p];
                dig++;
            end
            if (!leading || dig != 0 || p == u2d_pkg::N_PLACES - 1) begin
                leading      = 1'b0;
                d.digit_char = u2d_pkg::ASCII_ZERO + dig[u2d_pkg::CHAR_W-1:0];
                d.last       = (p == u2d_pkg::N_PLACES - 1);
                digits_due.push_back(d);
            end
        end
    endfunction

    function automatic void push_typed_digits(input string text);
        byte          ch;
        t_ascii_digit d;
        for (int k = 0; k < text.len(); k++) begin
            ch           = text.getc(k);
            d.digit_char = ch[u2d_pkg::CHAR_W-1:0];
            d.last       = (k == text.len() - 1);
            digits_due.push_back(d);
        end
    endfunction

    task automatic send_value(input logic [u2d_pkg::VAL_W-1:0] value, input string text);
        i_value <= value;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        if (text.len() == 0) begin
            push_decimal_digits(value);
        end else begin
            push_typed_digits(text);
        end
        values_sent++;
        if (bursts_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
    endtask

    initial begin
        logic [u2d_pkg::VAL_W-1:0] v;
        int unsigned               place_digit;
        repeat (11) @(posedge i_clk);
        i_rst_n   <= 1'b1;
        bursts_on  = 1'b1;
        for (int n = 0; n < N_DIR; n++) begin
            send_value(DIRECTED_VALUES[n], directed_text[n]);
        end
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM - QUIET_TAIL) begin
                bursts_on = 1'b0;
            end
            case ($urandom_range(0, 5))
                0: v = $urandom_range(0, 9);
                1: v = $urandom_range(10, 99);
                2: v = $urandom_range(100, 999);
                3: v = $urandom_range(1000, 9999);
                4: begin
                    // build five digits with frequent inner zeros
                    place_digit = 0;
                    for (int p = 0; p < u2d_pkg::N_PLACES; p++) begin
                        place_digit += DECADES[p] *
                            ($urandom_range(0, 1) ? 0 : $urandom_range(1, 9));
                    end
                    if (place_digit > 65535) begin
                        place_digit -= 40000;
                    end
                    v = place_digit[u2d_pkg::VAL_W-1:0];
                end
                default: v = $urandom_range(0, 65535);
            endcase
            send_value(v, "");
        end
        i_valid <= 1'b0;
        while (digits_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (digits_due.size() != 0) begin
            $display("%0d expected words never arrived", digits_due.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("u16_to_decimal_ascii regression: pass");
        end else begin
            $display("u16_to_decimal_ascii regression: fail");
        end
        $finish;
    end

    initial begin
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (!pressure_done && values_sent >= PRESSURE_AT) begin
                // hold the output long enough to back up the input
                pressure_done = 1'b1;
                i_stall <= 1'b1;
                repeat (PRESSURE_CYCLES) @(posedge i_clk);
                i_stall <= 1'b0;
            end else if (bursts_on && $urandom_range(0, 5) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
                i_stall <= 1'b0;
                if ($urandom_range(0, 2) == 0) begin
                    repeat ($urandom_range(20, 80)) @(posedge i_clk);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_ascii_digit want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (digits_due.size() == 0) begin
                if (fail_count < MAX_REPORTS) begin
                    $display("unexpected word: char %0d last %0b", o_digit_char, o_last);
                end
                fail_count++;
            end else begin
                want = digits_due.pop_front();
                if (o_digit_char !== want.digit_char || o_last !== want.last) begin
                    if (fail_count < MAX_REPORTS) begin
                        $display("mismatch: got char %0d last %0b, expected char %0d last %0b",
                                 o_digit_char, o_last, want.digit_char, want.last);
                    end
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("u16_to_decimal_ascii regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
